// ----- sv/kcd_pkg.sv -----
package kcd_pkg;

	typedef enum logic [3:0] {
		EV_SKIPPED    = 4'd0,
		EV_IRQ        = 4'd1,
		EV_MASK       = 4'd2,
		EV_HANDLES    = 4'd3,
		EV_FLAGS      = 4'd4,
		EV_HELD       = 4'd5,
		EV_MAPPING    = 4'd6,
		EV_VERSION    = 4'd7,
		EV_UNHANDLED  = 4'd8,
		EV_INCOMPLETE = 4'd9
	} event_kind_t;

	localparam logic [31:0] WORD_SKIP = 32'hFFFF_FFFF;

	localparam logic [11:0] SEL_IRQ     = 12'hF00;
	localparam logic [11:0] CLS_IRQ     = 12'hE00;
	localparam logic [11:0] SEL_MASK    = 12'hF80;
	localparam logic [11:0] CLS_MASK    = 12'hF00;
	localparam logic [11:0] SEL_HANDLES = 12'hFF0;
	localparam logic [11:0] CLS_HANDLES = 12'hFE0;
	localparam logic [11:0] SEL_FLAGS   = 12'hFF8;
	localparam logic [11:0] CLS_FLAGS   = 12'hFF0;
	localparam logic [11:0] SEL_RANGE   = 12'hFFE;
	localparam logic [11:0] CLS_RANGE   = 12'hFF8;
	localparam logic [11:0] SEL_PAGE    = 12'hFFF;
	localparam logic [11:0] CLS_PAGE    = 12'hFFE;
	localparam logic [11:0] SEL_VERSION = 12'hFE0;
	localparam logic [11:0] CLS_VERSION = 12'hFC0;

	localparam int          MASK_GROUP_BITS = 24;
	localparam int          MASK_CAP        = 192;
	localparam logic [31:0] PAGE_BYTES      = 32'd4096;

endpackage

// ----- sv/kernel_capability_descriptor_decoder.sv -----
// Capability descriptor decoder.
// The input channel (in_valid, in_ready) takes one 32-bit descriptor word per
// cycle while in_ready is high, with list_end marking the last word of a list.
// The output channel (out_valid, out_ready) gives one result word per event,
// with the event kind, mapping fields and the current settings after the event.
// A word passes an input register and then an output register.
// Most words give one result; while the receiver takes every result, the
// block sustains one word per cycle.
// A word that follows a held range start but is not its end gives two results,
// so it stays in the input register until both results are loaded.
// When the receiver stalls, the result holds in the output register, one more
// word waits in the input register, and in_ready then drops.
// Reset clears the syscall mask, the handle size, the flags, the version and
// any held range start, and empties both registers.
module kernel_capability_descriptor_decoder import kcd_pkg::*; #(
	parameter int SYSCALL_MASK_BITS = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] descriptor,
	input  logic        list_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  event_kind,
	output logic [31:0] map_base,
	output logic [31:0] map_length,
	output logic        map_read_only,
	output logic        map_extra_flag,
	output logic [9:0]  handle_limit,
	output logic [15:0] misc_flag_bits,
	output logic [15:0] version_word,
	output logic [63:0] mask_low_half,
	output logic [63:0] mask_high_half,
	output logic        run_last
);

	logic        valid_s1;
	logic [31:0] descriptor_s1;
	logic        list_end_s1;

	logic [SYSCALL_MASK_BITS-1:0] mask_q;
	logic [SYSCALL_MASK_BITS-1:0] mask_upd;
	logic [SYSCALL_MASK_BITS-1:0] mask_nxt;
	logic [9:0]  handle_q,  handle_nxt;
	logic [15:0] flags_q,   flags_nxt;
	logic [15:0] version_q, version_nxt;
	logic [20:0] start_q,   start_nxt;
	logic        pend_q,    pend_nxt;

	logic        out_valid_q;
	event_kind_t kind_q,    kind_c;
	logic [31:0] base_q,    base_c;
	logic [31:0] length_q,  length_c;
	logic        ro_q,      ro_c;
	logic        extra_q,   extra_c;
	logic        last_q,    last_c;

	logic [11:0] cls;
	logic [31:0] range_s;
	logic [31:0] range_e;
	logic        out_load;
	logic [127:0] mask_wide;

	assign out_load = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || (out_load && last_c);

	kcd_mask_update #(
		.MASK_BITS (SYSCALL_MASK_BITS)
	) u_mask_update (
		.mask_cur  (mask_q),
		.group     (descriptor_s1[26:24]),
		.bits      (descriptor_s1[23:0]),
		.mask_next (mask_upd)
	);

	assign cls     = descriptor_s1[31:20];
	assign range_s = {start_q[19:0], 12'd0};
	assign range_e = {descriptor_s1[19:0], 12'd0};

	always_comb begin
		kind_c      = EV_UNHANDLED;
		base_c      = '0;
		length_c    = '0;
		ro_c        = 1'b0;
		extra_c     = 1'b0;
		last_c      = 1'b1;
		mask_nxt    = mask_q;
		handle_nxt  = handle_q;
		flags_nxt   = flags_q;
		version_nxt = version_q;
		start_nxt   = start_q;
		pend_nxt    = pend_q;
		if (pend_q) begin
			pend_nxt = 1'b0;
			if ((cls & SEL_RANGE) == CLS_RANGE) begin
				kind_c   = EV_MAPPING;
				length_c = (range_s < range_e) ? (range_e - range_s) : '0;
				base_c   = range_s;
				ro_c     = start_q[20];
				extra_c  = descriptor_s1[20];
			end else begin
				kind_c = EV_INCOMPLETE;
				last_c = 1'b0;
			end
		end else if (descriptor_s1 == WORD_SKIP) begin
			kind_c = EV_SKIPPED;
		end else if ((cls & SEL_IRQ) == CLS_IRQ) begin
			kind_c = EV_IRQ;
		end else if ((cls & SEL_MASK) == CLS_MASK) begin
			kind_c   = EV_MASK;
			mask_nxt = mask_upd;
		end else if ((cls & SEL_HANDLES) == CLS_HANDLES) begin
			kind_c     = EV_HANDLES;
			handle_nxt = descriptor_s1[9:0];
		end else if ((cls & SEL_FLAGS) == CLS_FLAGS) begin
			kind_c    = EV_FLAGS;
			flags_nxt = descriptor_s1[15:0];
		end else if ((cls & SEL_RANGE) == CLS_RANGE) begin
			if (list_end_s1) begin
				kind_c = EV_INCOMPLETE;
			end else begin
				kind_c    = EV_HELD;
				start_nxt = descriptor_s1[20:0];
				pend_nxt  = 1'b1;
			end
		end else if ((cls & SEL_PAGE) == CLS_PAGE) begin
			kind_c   = EV_MAPPING;
			base_c   = {descriptor_s1[19:0], 12'd0};
			length_c = PAGE_BYTES;
		end else if ((cls & SEL_VERSION) == CLS_VERSION) begin
			kind_c      = EV_VERSION;
			version_nxt = descriptor_s1[15:0];
		end
		if (last_c && list_end_s1) begin
			pend_nxt = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			descriptor_s1 <= descriptor;
			list_end_s1   <= list_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			handle_q    <= '0;
			flags_q     <= '0;
			version_q   <= '0;
			start_q     <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				mask_q    <= mask_nxt;
				handle_q  <= handle_nxt;
				flags_q   <= flags_nxt;
				version_q <= version_nxt;
				start_q   <= start_nxt;
				pend_q    <= pend_nxt;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			kind_q   <= kind_c;
			base_q   <= base_c;
			length_q <= length_c;
			ro_q     <= ro_c;
			extra_q  <= extra_c;
			last_q   <= last_c;
		end
	end

	assign mask_wide = 128'(mask_q);

	assign out_valid      = out_valid_q;
	assign event_kind     = kind_q;
	assign map_base       = base_q;
	assign map_length     = length_q;
	assign map_read_only  = ro_q;
	assign map_extra_flag = extra_q;
	assign handle_limit   = handle_q;
	assign misc_flag_bits = flags_q;
	assign version_word   = version_q;
	assign mask_low_half  = mask_wide[63:0];
	assign mask_high_half = mask_wide[127:64];
	assign run_last       = last_q;

endmodule

// ----- sv/kcd_mask_update.sv -----
module kcd_mask_update import kcd_pkg::*; #(
	parameter int MASK_BITS = 128
) (
	input  logic [MASK_BITS-1:0]       mask_cur,
	input  logic [2:0]                 group,
	input  logic [MASK_GROUP_BITS-1:0] bits,
	output logic [MASK_BITS-1:0]       mask_next
);

	logic [MASK_GROUP_BITS-1:0] keep;

	// A bit is written only up to the highest set bit of the group.
	always_comb begin
		for (int i = 0; i < MASK_GROUP_BITS; i++) begin
			keep[i] = |(bits >> i);
		end
		for (int p = 0; p < MASK_BITS; p++) begin
			if (group == 3'(p / MASK_GROUP_BITS) && keep[p % MASK_GROUP_BITS]) begin
				mask_next[p] = bits[p % MASK_GROUP_BITS];
			end else begin
				mask_next[p] = mask_cur[p];
			end
		end
	end

endmodule

// ----- sv/kcd_checker.sv -----
module kcd_checker import kcd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [31:0] descriptor,
	input logic        list_end,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  event_kind,
	input logic [31:0] map_base,
	input logic [31:0] map_length,
	input logic        map_read_only,
	input logic        map_extra_flag,
	input logic [9:0]  handle_limit,
	input logic [15:0] misc_flag_bits,
	input logic [15:0] version_word,
	input logic [63:0] mask_low_half,
	input logic [63:0] mask_high_half,
	input logic        run_last
);

	// A waiting input word keeps its payload until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(descriptor) && $stable(list_end))
		else $error("input word changed while waiting");

	// A stalled result word keeps its kind and its settings.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_kind)
			&& $stable(handle_limit) && $stable(misc_flag_bits) && $stable(version_word)
			&& $stable(mask_low_half) && $stable(mask_high_half))
		else $error("result word changed while stalled");

	a_map_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind != EV_MAPPING |-> map_base == '0 && map_length == '0
			&& !map_read_only && !map_extra_flag)
		else $error("mapping fields set on a non-mapping result");

	a_first_incomplete: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_last |-> event_kind == EV_INCOMPLETE)
		else $error("only a dropped range start may precede another result");

	a_followup: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !run_last |=> out_valid && run_last
			&& event_kind != EV_INCOMPLETE && event_kind != EV_HELD)
		else $error("a dropped range start was not followed by its decoded word");

endmodule

bind kernel_capability_descriptor_decoder kcd_checker u_kcd_checker (.*);
